// ===== hw/rtl/siq_pkg.sv =====
package siq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // cell commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SHIFT  = 2'd2;
  localparam logic [1:0] CMD_ROTATE = 2'd3;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } siq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } siq_out_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] head;
  } siq_ctrl_t;

endpackage

// ===== hw/rtl/siq_cell.sv =====
module siq_cell
  import siq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                     clk,
  input  siq_ctrl_t                ctrl,
  input  logic [CW-1:0]            count,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_gt,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     gt
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     occ;
  logic                     at_tail;
  logic                     is_last;

  assign occ     = CW'(IDX) < count;
  assign at_tail = count == CW'(IDX);
  assign is_last = count == CW'(IDX + 1);
  assign gt      = occ && (entry_r > ctrl.value);
  assign data    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        // larger entries move up one cell, the new value lands in the gap
        if (left_gt) begin
          entry_nxt = left_data;
        end else if (gt || at_tail) begin
          entry_nxt = ctrl.value;
        end
      end
      CMD_SHIFT: begin
        entry_nxt = right_data;
      end
      CMD_ROTATE: begin
        // head wraps to the last occupied cell
        entry_nxt = is_last ? ctrl.head : right_data;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_insert_queue_unit.sv =====
// insert and remove: result registered, valid in the cycle after the transaction is accepted
// insert and remove sustain one transaction per cycle while out_ready is high; dump of n
// entries streams n results from the head cell, one per cycle while out_ready is high
// once the unit has entered the dump state, and blocks input until the last one
// an empty dump or an unused op holds no state
// rst_n (synchronous) clears the fill count, dump state and output valid, not the cells
module sorted_insert_queue_unit
  import siq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  siq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output siq_out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                     state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  siq_out_t                 out_r, out_nxt;
  siq_ctrl_t                ctrl;
  logic                     out_free;
  logic                     acc;
  logic                     full;
  logic                     empty;
  logic                     dump_last;
  logic [CW-1:0]            cnt_inc;
  logic [CW-1:0]            cnt_dec;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic                     cell_gt [CAPACITY];

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign full      = cnt_r == CW'(CAPACITY);
  assign empty     = cnt_r == '0;
  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign dump_last = idx_r == cnt_dec;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctrl.cmd      = CMD_HOLD;
    ctrl.value    = in_data.value;
    ctrl.head     = cell_q[0];

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_data.op)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = '{STAT_FULL, '0, COUNT_W'(cnt_r), 1'b1};
              end else begin
                ctrl.cmd = CMD_INSERT;
                cnt_nxt  = cnt_inc;
                out_nxt  = '{STAT_OK, '0, COUNT_W'(cnt_inc), 1'b1};
              end
            end
            OP_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_nxt = '{STAT_EMPTY, '0, '0, 1'b1};
              end else begin
                ctrl.cmd = CMD_SHIFT;
                cnt_nxt  = cnt_dec;
                out_nxt  = '{STAT_OK, cell_q[0], COUNT_W'(cnt_dec), 1'b1};
              end
            end
            OP_DUMP: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{STAT_EMPTY, '0, '0, 1'b1};
              end else begin
                state_nxt = S_DUMP;
                idx_nxt   = '0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          // emit the head and rotate, n rotations restore the order
          ctrl.cmd      = CMD_ROTATE;
          out_valid_nxt = 1'b1;
          out_nxt       = '{STAT_OK, cell_q[0], COUNT_W'(cnt_r), dump_last};
          idx_nxt       = idx_r + 1'b1;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_gt   = 1'b0;
    end else begin : g_mid
      assign left_data = cell_q[i-1];
      assign left_gt   = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_data = cell_q[i];
    end else begin : g_inner
      assign right_data = cell_q[i+1];
    end

    siq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (cnt_r),
      .left_data  (left_data),
      .left_gt    (left_gt),
      .right_data (right_data),
      .data       (cell_q[i]),
      .gt         (cell_gt[i])
    );
  end

endmodule
